// ===== sv/pgd_pkg.sv =====
// Package with the item types, phase and kind codes of the postings gap decoder.
`default_nettype none

package pgd_pkg;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ID    = 2'd1,
    PH_COUNT = 2'd2,
    PH_POS   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DOC   = 2'd0,
    KIND_POS   = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  localparam logic CFG_SWAP_BYTES     = 1'b0;
  localparam logic CFG_WITH_POSITIONS = 1'b1;

  typedef struct packed {
    logic [31:0] word;
    logic        start_req;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic [31:0] position_count;
    logic        last_in_list;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/postings_gap_decoder.sv =====
// Top level of the postings gap decoder: decode state, result register and checks.
//
// Input items carry one 32-bit word of a postings list and a start mark; a word
// with the start mark is the document count of a new list. Result items carry a
// kind (document, position or empty list marker), an absolute value, the
// position count of a document and a last-in-list mark. Both channels use
// valid and ready. Configuration is written through cfg_we, cfg_index and
// cfg_data: index 0 selects byte swapping, index 1 selects positional mode.
// The user must write it only while the block is idle; the block does not enforce this.
// Each accepted item is decoded in the cycle it is taken, with one add and one
// counter decrement, and its result, if any, shows in the result register the
// next cycle; the block takes one item per cycle while in_ready is high. The result
// register is the only buffer, so a new item is taken while the receiver is
// stalled only when that register is empty; when it is full and not taken,
// in_ready is low. Words that give no result never occupy it.
// Reset clears the decoder to idle, empties the result register and sets both
// configuration bits to one.
`default_nettype none

module postings_gap_decoder (
  input  wire               clk,
  input  wire               rst,
  input  wire               cfg_we,
  input  wire               cfg_index,
  input  wire               cfg_data,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire pgd_pkg::in_item_t in_data,
  output logic              out_valid,
  input  wire               out_ready,
  output pgd_pkg::out_item_t out_data
);

  logic swap_bytes;
  logic with_positions;

  pgd_pkg::phase_t phase, phase_next;
  logic [31:0] docs_left, docs_left_next;
  logic [31:0] positions_left, positions_left_next;
  logic [31:0] previous_doc_id, previous_doc_id_next;
  logic [31:0] pending_doc_id, pending_doc_id_next;
  logic [31:0] previous_position, previous_position_next;

  logic               in_accept;
  logic [31:0]        w;
  logic [31:0]        docs_dec;
  logic [31:0]        pos_dec;
  logic [31:0]        sum;
  logic               produce;
  pgd_pkg::out_item_t result;

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  assign w = swap_bytes ? {in_data.word[7:0], in_data.word[15:8],
                           in_data.word[23:16], in_data.word[31:24]}
                        : in_data.word;
  assign docs_dec = docs_left - 32'd1;
  assign pos_dec  = positions_left - 32'd1;

  always_comb begin
    phase_next             = phase;
    docs_left_next         = docs_left;
    positions_left_next    = positions_left;
    previous_doc_id_next   = previous_doc_id;
    pending_doc_id_next    = pending_doc_id;
    previous_position_next = previous_position;
    produce                = 1'b0;
    result                 = '{kind: pgd_pkg::KIND_DOC, value: 32'd0,
                               position_count: 32'd0, last_in_list: 1'b0};
    sum                    = 32'd0;
    if (in_data.start_req) begin
      positions_left_next    = 32'd0;
      previous_position_next = 32'd0;
      previous_doc_id_next   = 32'd0;
      pending_doc_id_next    = 32'd0;
      docs_left_next         = w;
      if (w == 32'd0) begin
        phase_next          = pgd_pkg::PH_IDLE;
        produce             = 1'b1;
        result.kind         = pgd_pkg::KIND_EMPTY;
        result.last_in_list = 1'b1;
      end else begin
        phase_next = pgd_pkg::PH_ID;
      end
    end else begin
      case (phase)
        pgd_pkg::PH_ID: begin
          if (with_positions) begin
            sum                  = previous_doc_id + w;
            previous_doc_id_next = sum;
            pending_doc_id_next  = sum;
            phase_next           = pgd_pkg::PH_COUNT;
          end else begin
            previous_doc_id_next = w;
            docs_left_next       = docs_dec;
            produce              = 1'b1;
            result.value         = w;
            result.last_in_list  = (docs_dec == 32'd0);
            if (docs_dec == 32'd0) begin
              phase_next = pgd_pkg::PH_IDLE;
            end
          end
        end
        pgd_pkg::PH_COUNT: begin
          docs_left_next        = docs_dec;
          produce               = 1'b1;
          result.value          = pending_doc_id;
          result.position_count = w;
          result.last_in_list   = (docs_dec == 32'd0) && (w == 32'd0);
          if (w == 32'd0) begin
            phase_next = (docs_dec == 32'd0) ? pgd_pkg::PH_IDLE : pgd_pkg::PH_ID;
          end else begin
            positions_left_next    = w;
            previous_position_next = 32'd0;
            phase_next             = pgd_pkg::PH_POS;
          end
        end
        pgd_pkg::PH_POS: begin
          sum                    = previous_position + w;
          previous_position_next = sum;
          positions_left_next    = pos_dec;
          produce                = 1'b1;
          result.kind            = pgd_pkg::KIND_POS;
          result.value           = sum;
          result.last_in_list    = (pos_dec == 32'd0) && (docs_left == 32'd0);
          if (pos_dec == 32'd0) begin
            phase_next = (docs_left == 32'd0) ? pgd_pkg::PH_IDLE : pgd_pkg::PH_ID;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      swap_bytes     <= 1'b1;
      with_positions <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == pgd_pkg::CFG_SWAP_BYTES) begin
        swap_bytes <= cfg_data;
      end else begin
        with_positions <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= pgd_pkg::PH_IDLE;
      docs_left         <= 32'd0;
      positions_left    <= 32'd0;
      previous_doc_id   <= 32'd0;
      pending_doc_id    <= 32'd0;
      previous_position <= 32'd0;
    end else if (in_accept) begin
      phase             <= phase_next;
      docs_left         <= docs_left_next;
      positions_left    <= positions_left_next;
      previous_doc_id   <= previous_doc_id_next;
      pending_doc_id    <= pending_doc_id_next;
      previous_position <= previous_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && produce) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && produce) begin
      out_data <= result;
    end
  end

  a_empty_list: assert property (@(posedge clk) disable iff (rst)
    in_accept && in_data.start_req && in_data.word == 32'd0
    |=> out_valid && out_data.kind == pgd_pkg::KIND_EMPTY && out_data.last_in_list)
    else $error("empty list did not give a final marker item");

  a_marker_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == pgd_pkg::KIND_EMPTY
    |-> out_data.value == 32'd0 && out_data.position_count == 32'd0)
    else $error("empty list marker carries a nonzero payload");

  a_position_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == pgd_pkg::KIND_POS |-> out_data.position_count == 32'd0)
    else $error("position item carries a position count");

  a_idle_ignore: assert property (@(posedge clk) disable iff (rst)
    in_accept && !in_data.start_req && phase == pgd_pkg::PH_IDLE
    |=> phase == pgd_pkg::PH_IDLE && docs_left == $past(docs_left))
    else $error("word without start mark left the idle phase");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the postings gap decoder with a result-predicting scoreboard.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  class gap_decode_tracker;
    bit                 swap;
    bit                 with_pos;
    pgd_pkg::phase_t    phase;
    logic [31:0]        docs_left;
    logic [31:0]        positions_left;
    logic [31:0]        prev_doc;
    logic [31:0]        pending_doc;
    logic [31:0]        prev_pos;
    pgd_pkg::out_item_t results_due[$];
    int                 mismatches;

    function new();
      swap = 1'b1;
      with_pos = 1'b1;
      phase = pgd_pkg::PH_IDLE;
      docs_left = '0;
      positions_left = '0;
      prev_doc = '0;
      pending_doc = '0;
      prev_pos = '0;
      mismatches = 0;
    endfunction

    static function logic [31:0] reverse_bytes(logic [31:0] w);
      return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function void set_register(logic idx, bit val);
      if (idx == pgd_pkg::CFG_SWAP_BYTES) begin
        swap = val;
      end else begin
        with_pos = val;
      end
    endfunction

    function void queue_result(pgd_pkg::kind_t kind, logic [31:0] value,
                               logic [31:0] count, bit last);
      pgd_pkg::out_item_t r;
      r.kind = kind;
      r.value = value;
      r.position_count = count;
      r.last_in_list = last;
      results_due.insert(results_due.size(), r);
    endfunction

    function void take_word(pgd_pkg::in_item_t item);
      logic [31:0] w;
      w = swap ? reverse_bytes(item.word) : item.word;
      if (item.start_req) begin
        positions_left = '0;
        prev_pos = '0;
        prev_doc = '0;
        pending_doc = '0;
        docs_left = w;
        if (w == 0) begin
          phase = pgd_pkg::PH_IDLE;
          queue_result(pgd_pkg::KIND_EMPTY, '0, '0, 1'b1);
        end else begin
          phase = pgd_pkg::PH_ID;
        end
        return;
      end
      case (phase)
        pgd_pkg::PH_ID: begin
          if (with_pos) begin
            prev_doc = prev_doc + w;
            pending_doc = prev_doc;
            phase = pgd_pkg::PH_COUNT;
          end else begin
            prev_doc = w;
            docs_left = docs_left - 1;
            queue_result(pgd_pkg::KIND_DOC, w, '0, docs_left == 0);
            if (docs_left == 0) phase = pgd_pkg::PH_IDLE;
          end
        end
        pgd_pkg::PH_COUNT: begin
          docs_left = docs_left - 1;
          queue_result(pgd_pkg::KIND_DOC, pending_doc, w, docs_left == 0 && w == 0);
          if (w == 0) begin
            if (docs_left == 0) phase = pgd_pkg::PH_IDLE;
            else phase = pgd_pkg::PH_ID;
          end else begin
            positions_left = w;
            prev_pos = '0;
            phase = pgd_pkg::PH_POS;
          end
        end
        pgd_pkg::PH_POS: begin
          prev_pos = prev_pos + w;
          positions_left = positions_left - 1;
          queue_result(pgd_pkg::KIND_POS, prev_pos, '0,
                       positions_left == 0 && docs_left == 0);
          if (positions_left == 0) begin
            if (docs_left == 0) phase = pgd_pkg::PH_IDLE;
            else phase = pgd_pkg::PH_ID;
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(pgd_pkg::out_item_t got);
      pgd_pkg::out_item_t want;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d value %h",
                 $time, got.kind, got.value);
        mismatches++;
        return;
      end
      want = results_due.pop_front();
      compare_field("kind", 32'(want.kind), 32'(got.kind));
      compare_field("value", want.value, got.value);
      compare_field("position_count", want.position_count, got.position_count);
      compare_field("last_in_list", 32'(want.last_in_list), 32'(got.last_in_list));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic               cfg_index;
  logic               cfg_data;
  logic               in_valid;
  logic               in_ready;
  pgd_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  pgd_pkg::out_item_t out_data;

  gap_decode_tracker tracker = new();

  bit cur_swap = 1'b1;
  bit cur_with_pos = 1'b1;
  bit steady = 1'b0;
  int items_sent = 0;

  postings_gap_decoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) tracker.take_word(in_data);
      if (out_valid && out_ready) tracker.check_result(out_data);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic logic [31:0] random_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    if (r < 6) return $urandom_range(0, 255);
    return $urandom;
  endfunction

  task automatic send_word(input logic [31:0] logical, input bit start, input bit counted);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data.word <= cur_swap ? gap_decode_tracker::reverse_bytes(logical) : logical;
    in_data.start_req <= start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (counted) items_sent++;
  endtask

  task automatic settle();
    @(negedge clk) in_valid <= 1'b0;
    while (tracker.results_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_mode(input bit swap, input bit with_pos);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= pgd_pkg::CFG_SWAP_BYTES;
    cfg_data <= swap;
    @(negedge clk);
    cfg_index <= pgd_pkg::CFG_WITH_POSITIONS;
    cfg_data <= with_pos;
    @(negedge clk) cfg_we <= 1'b0;
    tracker.set_register(pgd_pkg::CFG_SWAP_BYTES, swap);
    tracker.set_register(pgd_pkg::CFG_WITH_POSITIONS, with_pos);
    cur_swap = swap;
    cur_with_pos = with_pos;
  endtask

  task automatic send_list(input bit broken);
    logic [31:0] words[$];
    logic [31:0] ndocs;
    logic [31:0] count;
    int          nbuilt;
    int          npos;
    int          cut;
    ndocs = $urandom_range(1, 5);
    if (broken && $urandom_range(0, 2) == 0) ndocs = $urandom;
    nbuilt = (ndocs > 6) ? 6 : int'(ndocs);
    for (int d = 0; d < nbuilt; d++) begin
      words.insert(words.size(), random_word());
      if (cur_with_pos) begin
        count = $urandom_range(0, 4);
        if (broken && $urandom_range(0, 2) == 0) count = $urandom;
        words.insert(words.size(), count);
        npos = (count > 4) ? 4 : int'(count);
        for (int p = 0; p < npos; p++) words.insert(words.size(), random_word());
      end
    end
    if (broken && words.size() > 0) begin
      cut = $urandom_range(0, words.size() - 1);
      while (words.size() > cut) void'(words.pop_back());
    end
    send_word(ndocs, 1'b1, 1'b1);
    foreach (words[i]) send_word(words[i], 1'b0, 1'b1);
  endtask

  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
        @(negedge clk) out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk) out_ready <= 1'b1;
      repeat ($urandom_range(0, 8)) @(negedge clk);
    end
  end

  initial begin
    #10ms;
    $display("FAIL postings_gap_decoder");
    $finish;
  end

  initial begin
    int target;
    int phase_no;
    int phase_len;
    int phase_start;
    int r;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Empty list, then a stray word while idle.
    send_word(32'h0, 1'b1, 1'b1);
    send_word(32'h1234_5678, 1'b0, 1'b1);
    // Zero-position document, id wraparound, position wraparound.
    send_word(32'd2, 1'b1, 1'b1);
    send_word(32'd5, 1'b0, 1'b1);
    send_word(32'd0, 1'b0, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0, 1'b1);
    send_word(32'd2, 1'b0, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0, 1'b1);
    send_word(32'd3, 1'b0, 1'b1);
    // Largest count, abandoned by a new start; the last document has no positions.
    send_word(32'hFFFF_FFFF, 1'b1, 1'b1);
    send_word(32'd7, 1'b0, 1'b1);
    send_word(32'd1, 1'b0, 1'b1);
    send_word(32'd1, 1'b1, 1'b1);
    send_word(32'd0, 1'b0, 1'b1);
    send_word(32'd0, 1'b0, 1'b1);
    settle();
    set_mode(1'b0, 1'b0);
    send_word(32'd2, 1'b1, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0, 1'b1);
    send_word(32'd0, 1'b0, 1'b1);
    // Switch from plain to positional in the middle of a list.
    send_word(32'd2, 1'b1, 1'b1);
    send_word(32'd9, 1'b0, 1'b1);
    settle();
    set_mode(1'b0, 1'b1);
    send_word(32'd1, 1'b0, 1'b1);
    send_word(32'd1, 1'b0, 1'b1);
    send_word(32'h8000_0000, 1'b0, 1'b1);
    // Switch to plain while a position count is still due.
    send_word(32'd2, 1'b1, 1'b1);
    send_word(32'd4, 1'b0, 1'b1);
    settle();
    set_mode(1'b1, 1'b0);
    send_word(32'd1, 1'b0, 1'b1);
    send_word(32'd6, 1'b0, 1'b1);
    send_word(32'hAAAA_5555, 1'b0, 1'b1);

    target = items_sent + 1200;
    phase_no = 0;
    while (items_sent < target) begin
      settle();
      if (phase_no < 4) begin
        set_mode(phase_no[0], phase_no[1]);
      end else begin
        set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      steady = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(60, 200);
      phase_start = items_sent;
      while (items_sent - phase_start < phase_len && items_sent < target) begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          send_word(32'h0, 1'b1, 1'b1);
        end else if (r < 15) begin
          send_list(1'b1);
        end else begin
          send_list(1'b0);
          if ($urandom_range(0, 19) == 0) send_word($urandom, 1'b0, 1'b0);
        end
      end
      phase_no++;
    end

    settle();
    if (tracker.mismatches == 0) begin
      $display("PASS postings_gap_decoder");
    end else begin
      $display("FAIL postings_gap_decoder");
    end
    $finish;
  end

endmodule

`default_nettype wire
